// ----- design/tdoa_pkg.sv -----
package tdoa_pkg;

    localparam int ANCHOR_W   = 8;
    localparam int FLOAT_W    = 32;
    localparam int AGE_W      = 16;
    localparam int TIME_W     = 32;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_W     = 4;
    localparam int PAIRS_W    = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0]  REG_MAX_AGE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_BACK_TOL  = 8'd1;
    localparam logic [CFG_DATA_W-1:0] MAX_AGE_RST   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] BACK_TOL_RST  = 16'd100;

    localparam logic [7:0]         FP_EXP_ONES = 8'hFF;
    localparam logic [FLOAT_W-1:0] FP_POS_ZERO = 32'h0000_0000;
    localparam logic [FLOAT_W-1:0] FP_SIGN     = 32'h8000_0000;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_OK         = 3'd0,
        OC_BAD_IDS    = 3'd1,
        OC_NON_FINITE = 3'd2,
        OC_TOO_OLD    = 3'd3,
        OC_FULL       = 3'd4,
        OC_BACKWARDS  = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_idx;
        logic inc_idx;
        logic emit_pre;
        logic emit_final;
    } t_ctl_cmd;

    typedef struct packed {
        logic pre_ok;
        logic search_end;
        logic match;
        logic out_free;
    } t_ctl_sts;

endpackage

// ----- design/tdoa_if.sv -----
interface tdoa_in_if;
    import tdoa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ANCHOR_W-1:0] anchor_first;
    logic [ANCHOR_W-1:0] anchor_second;
    logic [FLOAT_W-1:0]  diff_bits;
    logic [FLOAT_W-1:0]  diff_error_bits;
    logic [AGE_W-1:0]    sample_age;
    logic [TIME_W-1:0]   now_time;

    modport source (
        output valid, anchor_first, anchor_second, diff_bits, diff_error_bits,
               sample_age, now_time,
        input  ready
    );
    modport sink (
        input  valid, anchor_first, anchor_second, diff_bits, diff_error_bits,
               sample_age, now_time,
        output ready
    );
endinterface

interface tdoa_out_if;
    import tdoa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot_used;
    logic [PAIRS_W-1:0]   pairs_held;
    logic [TIME_W-1:0]    stamped_time;

    modport source (
        output valid, outcome, slot_used, pairs_held, stamped_time,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot_used, pairs_held, stamped_time,
        output ready
    );
endinterface

interface tdoa_cfg_if;
    import tdoa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

// ----- design/tdoa_ctrl.sv -----
module tdoa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tdoa_pkg::t_ctl_sts i_sts,
    output tdoa_pkg::t_ctl_cmd o_cmd
);
    import tdoa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.pre_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_pre = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_sts.search_end || i_sts.match) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tdoa_dpath.sv -----
module tdoa_dpath #(
    parameter int ANCHOR_LIMIT = 16,
    parameter int TABLE_DEPTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tdoa_in_if.sink            i_meas,
    tdoa_out_if.source         o_res,
    tdoa_cfg_if.sink           i_cfg,
    input  logic               i_in_ready,
    input  tdoa_pkg::t_ctl_cmd i_cmd,
    output tdoa_pkg::t_ctl_sts o_sts
);
    import tdoa_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [ANCHOR_W-1:0] LIMIT_C = ANCHOR_W'(ANCHOR_LIMIT);

    logic [CFG_DATA_W-1:0] r_max_age;
    logic [CFG_DATA_W-1:0] r_back_tol;

    logic [ANCHOR_W-1:0] r_a;
    logic [ANCHOR_W-1:0] r_b;
    logic [FLOAT_W-1:0]  r_diff;
    logic [FLOAT_W-1:0]  r_err;
    logic [AGE_W-1:0]    r_age;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_stamp;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;

    logic [ANCHOR_W-1:0] mem_lo    [TABLE_DEPTH];
    logic [ANCHOR_W-1:0] mem_hi    [TABLE_DEPTH];
    logic [FLOAT_W-1:0]  mem_diff  [TABLE_DEPTH];
    logic [FLOAT_W-1:0]  mem_err   [TABLE_DEPTH];
    logic [TIME_W-1:0]   mem_stamp [TABLE_DEPTH];
    logic [AGE_W-1:0]    mem_age   [TABLE_DEPTH];

    logic [ANCHOR_W-1:0] r_rd_lo;
    logic [ANCHOR_W-1:0] r_rd_hi;
    logic [TIME_W-1:0]   r_rd_stamp;

    logic                r_ov;
    t_outcome            r_oc;
    logic [SLOT_W-1:0]   r_oslot;
    logic [PAIRS_W-1:0]  r_opairs;
    logic [TIME_W-1:0]   r_ostamp;

    logic                swap;
    logic [ANCHOR_W-1:0] lo;
    logic [ANCHOR_W-1:0] hi;
    t_outcome            pre_code;
    logic [TIME_W-1:0]   stamp;
    logic                found;
    logic                full;
    logic [TIME_W-1:0]   delta;
    logic [TIME_W-1:0]   back_mag;
    logic                backwards;
    t_outcome            fin_code;
    logic                do_write;
    logic [31:0]         slot_ext;
    logic [31:0]         pairs_ext;
    logic [31:0]         count_ext;

    assign i_meas.ready = i_in_ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age  <= MAX_AGE_RST;
            r_back_tol <= BACK_TOL_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == REG_MAX_AGE) begin
                r_max_age <= i_cfg.wr_data;
            end else if (i_cfg.reg_index == REG_BACK_TOL) begin
                r_back_tol <= i_cfg.wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= i_meas.anchor_first;
            r_b     <= i_meas.anchor_second;
            r_diff  <= i_meas.diff_bits;
            r_err   <= i_meas.diff_error_bits;
            r_age   <= i_meas.sample_age;
            r_now   <= i_meas.now_time;
        end
        if (i_cmd.clr_idx) begin
            r_stamp <= stamp;
        end
    end

    always_comb begin
        swap = (r_b < r_a);
        lo   = swap ? r_b : r_a;
        hi   = swap ? r_a : r_b;
        stamp = (TIME_W'(r_age) > r_now) ? '0 : (r_now - TIME_W'(r_age));
        if (r_a >= LIMIT_C || r_b >= LIMIT_C || r_a == r_b) begin
            pre_code = OC_BAD_IDS;
        end else if (r_diff[30:23] == FP_EXP_ONES || r_err[30:23] == FP_EXP_ONES) begin
            pre_code = OC_NON_FINITE;
        end else if (r_age > r_max_age) begin
            pre_code = OC_TOO_OLD;
        end else begin
            pre_code = OC_OK;
        end
    end

    always_comb begin
        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end else if (i_cmd.inc_idx) begin
            n_idx = r_idx + 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_lo    <= mem_lo[n_idx[IW-1:0]];
        r_rd_hi    <= mem_hi[n_idx[IW-1:0]];
        r_rd_stamp <= mem_stamp[n_idx[IW-1:0]];
    end

    always_comb begin
        found     = (r_idx < r_count);
        full      = !found && (r_count == DEPTH_C);
        delta     = r_stamp - r_rd_stamp;
        back_mag  = r_rd_stamp - r_stamp;
        backwards = found && delta[TIME_W-1] && (back_mag > TIME_W'(r_back_tol));
        if (full) begin
            fin_code = OC_FULL;
        end else if (backwards) begin
            fin_code = OC_BACKWARDS;
        end else begin
            fin_code = OC_OK;
        end
        do_write = i_cmd.emit_final && (fin_code == OC_OK);
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem_lo[r_idx[IW-1:0]]    <= lo;
            mem_hi[r_idx[IW-1:0]]    <= hi;
            mem_diff[r_idx[IW-1:0]]  <= swap ? (r_diff ^ FP_SIGN) : r_diff;
            mem_err[r_idx[IW-1:0]]   <= r_err[FLOAT_W-1] ? FP_POS_ZERO : r_err;
            mem_stamp[r_idx[IW-1:0]] <= r_stamp;
            mem_age[r_idx[IW-1:0]]   <= r_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_write && !found) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign slot_ext  = 32'(r_idx);
    assign count_ext = 32'(r_count);
    assign pairs_ext = do_write && !found ? (count_ext + 32'd1) : count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit_pre || i_cmd.emit_final) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pre) begin
            r_oc     <= pre_code;
            r_oslot  <= '0;
            r_opairs <= count_ext[PAIRS_W-1:0];
            r_ostamp <= '0;
        end else if (i_cmd.emit_final) begin
            r_oc     <= fin_code;
            r_oslot  <= (fin_code == OC_OK) ? slot_ext[SLOT_W-1:0] : '0;
            r_opairs <= pairs_ext[PAIRS_W-1:0];
            r_ostamp <= (fin_code == OC_FULL) ? '0 : r_stamp;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.outcome      = r_oc;
    assign o_res.slot_used    = r_oslot;
    assign o_res.pairs_held   = r_opairs;
    assign o_res.stamped_time = r_ostamp;

    assign o_sts.pre_ok     = (pre_code == OC_OK);
    assign o_sts.search_end = !found;
    assign o_sts.match      = found && (r_rd_lo == lo) && (r_rd_hi == hi);
    assign o_sts.out_free   = !r_ov || o_res.ready;

endmodule

// ----- design/tdoa_pair_table_update.sv -----
// Range-difference pair table update. One measurement item enters on i_meas;
// one result item leaves on o_res for each, in order. An item rejected
// by the id, finiteness or age checks is answered from the check state;
// any other item, after accept and check, is scanned: one stored anchor
// pair per cycle is read from the table until the pair matches or the
// filled part ends, then the decide state decides, writes and answers.
// The result register lets the next item be taken while a result waits.
// Configuration: index 0 max_age_limit (reset 1000), index 1
// backwards_tolerance (reset 100); other indexes are ignored. Write only
// while the block holds no item in flight.
module tdoa_pair_table_update #(
    parameter int ANCHOR_LIMIT = 16,
    parameter int TABLE_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdoa_in_if.sink     i_meas,
    tdoa_out_if.source  o_res,
    tdoa_cfg_if.sink    i_cfg
);
    import tdoa_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;
    logic     w_in_ready;

    tdoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_meas.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tdoa_dpath #(
        .ANCHOR_LIMIT (ANCHOR_LIMIT),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_meas     (i_meas),
        .o_res      (o_res),
        .i_cfg      (i_cfg),
        .i_in_ready (w_in_ready),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

// ----- design/tdoa_chk.sv -----
module tdoa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  i_res_outcome,
    input logic [3:0]  i_res_slot,
    input logic [4:0]  i_res_pairs,
    input logic [31:0] i_res_stamp
);
    import tdoa_pkg::*;

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_outcome) && $stable(i_res_slot)
            && $stable(i_res_pairs) && $stable(i_res_stamp))
        else $error("result payload changed while stalled");

    a_reject_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_outcome != OC_OK |-> i_res_slot == '0)
        else $error("rejected item reports a slot");

    a_reject_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_outcome == OC_BAD_IDS || i_res_outcome == OC_NON_FINITE
            || i_res_outcome == OC_TOO_OLD || i_res_outcome == OC_FULL)
        |-> i_res_stamp == '0)
        else $error("early rejection reports a stamp");

endmodule

bind tdoa_pair_table_update tdoa_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_outcome (o_res.outcome),
    .i_res_slot    (o_res.slot_used),
    .i_res_pairs   (o_res.pairs_held),
    .i_res_stamp   (o_res.stamped_time)
);

// ----- tb/sv/tdoa_pair_table_update_test.sv -----
`timescale 1ns / 1ps

module tdoa_pair_table_update_test;
    import tdoa_pkg::*;

    localparam int ANCHOR_LIMIT = 16;
    localparam int TABLE_DEPTH  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int PARK_CYCLES  = 160;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

    typedef struct packed {
        logic [ANCHOR_W-1:0] a_first;
        logic [ANCHOR_W-1:0] a_second;
        logic [FLOAT_W-1:0]  diff;
        logic [FLOAT_W-1:0]  err;
        logic [AGE_W-1:0]    age;
        logic [TIME_W-1:0]   now;
    } meas_t;

    typedef struct packed {
        t_outcome            outcome;
        logic [SLOT_W-1:0]   slot;
        logic [PAIRS_W-1:0]  pairs;
        logic [TIME_W-1:0]   stamp;
    } res_t;

    logic i_clk;
    logic i_rst_n;

    tdoa_in_if  meas_if ();
    tdoa_out_if res_if ();
    tdoa_cfg_if cfg_if ();

    tdoa_pair_table_update #(
        .ANCHOR_LIMIT(ANCHOR_LIMIT),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_meas (meas_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    logic [ANCHOR_W-1:0] tbl_lo    [TABLE_DEPTH];
    logic [ANCHOR_W-1:0] tbl_hi    [TABLE_DEPTH];
    logic [FLOAT_W-1:0]  tbl_diff  [TABLE_DEPTH];
    logic [FLOAT_W-1:0]  tbl_err   [TABLE_DEPTH];
    logic [TIME_W-1:0]   tbl_stamp [TABLE_DEPTH];
    logic [AGE_W-1:0]    tbl_age   [TABLE_DEPTH];
    bit                  tbl_valid [TABLE_DEPTH];
    int                  n_pairs;
    logic [CFG_DATA_W-1:0] age_limit;
    logic [CFG_DATA_W-1:0] back_tol;

    meas_t pending_meas[$];
    res_t  pending_results[$];
    int    mismatches;
    int    stall_cycles;
    bit    meas_busy;
    bit    quiet;
    bit    park_req;
    int    src_gap;
    int    sink_gap;
    int    park_left;
    logic [TIME_W-1:0] clock_ms;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic res_t table_update(input meas_t m);
        res_t r;
        logic [ANCHOR_W-1:0] lo;
        logic [ANCHOR_W-1:0] hi;
        logic [ANCHOR_W-1:0] t;
        logic [FLOAT_W-1:0]  d;
        logic [TIME_W-1:0]   stamp;
        logic [TIME_W-1:0]   delta;
        logic [TIME_W-1:0]   mag;
        int slot;
        r.outcome = OC_OK;
        r.slot    = '0;
        r.stamp   = '0;
        lo = m.a_first;
        hi = m.a_second;
        d  = m.diff;
        if (lo >= ANCHOR_LIMIT || hi >= ANCHOR_LIMIT || lo == hi) begin
            r.outcome = OC_BAD_IDS;
        end else if (m.diff[30:23] == FP_EXP_ONES || m.err[30:23] == FP_EXP_ONES) begin
            r.outcome = OC_NON_FINITE;
        end else if (m.age > age_limit) begin
            r.outcome = OC_TOO_OLD;
        end else begin
            if (hi < lo) begin
                t  = lo;
                lo = hi;
                hi = t;
                d  = d ^ FP_SIGN;
            end
            slot = n_pairs;
            for (int i = 0; i < n_pairs; i++) begin
                if (slot == n_pairs && tbl_lo[i] == lo && tbl_hi[i] == hi) begin
                    slot = i;
                end
            end
            if (slot >= TABLE_DEPTH) begin
                r.outcome = OC_FULL;
            end else begin
                stamp = (m.age > m.now) ? '0 : m.now - m.age;
                delta = stamp - tbl_stamp[slot];
                mag   = ~delta + 32'd1;
                if (slot < n_pairs && tbl_valid[slot] && delta[31]
                        && mag > {16'h0, back_tol}) begin
                    r.outcome = OC_BACKWARDS;
                    r.stamp   = stamp;
                end else begin
                    if (slot == n_pairs) begin
                        n_pairs = n_pairs + 1;
                    end
                    tbl_lo[slot]    = lo;
                    tbl_hi[slot]    = hi;
                    tbl_diff[slot]  = d;
                    tbl_err[slot]   = m.err[31] ? FP_POS_ZERO : m.err;
                    tbl_stamp[slot] = stamp;
                    tbl_age[slot]   = m.age;
                    tbl_valid[slot] = 1'b1;
                    r.slot  = slot[SLOT_W-1:0];
                    r.stamp = stamp;
                end
            end
        end
        r.pairs = n_pairs[PAIRS_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin : feed
        meas_t m;
        if (!meas_busy) begin
            if (src_gap > 0) begin
                src_gap--;
                meas_if.valid <= 1'b0;
            end else if (pending_meas.size() > 0) begin
                m = pending_meas.pop_front();
                meas_if.anchor_first    <= m.a_first;
                meas_if.anchor_second   <= m.a_second;
                meas_if.diff_bits       <= m.diff;
                meas_if.diff_error_bits <= m.err;
                meas_if.sample_age      <= m.age;
                meas_if.now_time        <= m.now;
                meas_if.valid           <= 1'b1;
                meas_busy = 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) begin
                    src_gap = $urandom_range(1, 4);
                end
            end else begin
                meas_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : predict
        meas_t m;
        if (i_rst_n && meas_if.valid && meas_if.ready) begin
            m.a_first  = meas_if.anchor_first;
            m.a_second = meas_if.anchor_second;
            m.diff     = meas_if.diff_bits;
            m.err      = meas_if.diff_error_bits;
            m.age      = meas_if.sample_age;
            m.now      = meas_if.now_time;
            pending_results.push_back(table_update(m));
            meas_busy = 1'b0;
        end
    end

    always @(negedge i_clk) begin : sink_ctl
        if (park_req) begin
            park_left = PARK_CYCLES;
            park_req  = 1'b0;
        end
        if (park_left > 0) begin
            park_left--;
            res_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            res_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 3);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        res_t e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none expected, outcome %0d",
                         $time, res_if.outcome);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                check_field("outcome", 32'(e.outcome), 32'(res_if.outcome));
                check_field("slot_used", 32'(e.slot), 32'(res_if.slot_used));
                check_field("pairs_held", 32'(e.pairs), 32'(res_if.pairs_held));
                check_field("stamped_time", e.stamp, res_if.stamped_time);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((meas_if.valid && meas_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        if (idx == REG_MAX_AGE) begin
            age_limit = val;
        end else if (idx == REG_BACK_TOL) begin
            back_tol = val;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_meas.size() != 0 || meas_busy || pending_results.size() != 0);
    endtask

    task automatic add_meas(input logic [ANCHOR_W-1:0] a, input logic [ANCHOR_W-1:0] b,
                            input logic [FLOAT_W-1:0] d, input logic [FLOAT_W-1:0] e,
                            input logic [AGE_W-1:0] age, input logic [TIME_W-1:0] now);
        meas_t m;
        m.a_first  = a;
        m.a_second = b;
        m.diff     = d;
        m.err      = e;
        m.age      = age;
        m.now      = now;
        pending_meas.push_back(m);
    endtask

    task automatic add_random(input int count);
        meas_t m;
        int k;
        int r;
        for (int n = 0; n < count; n++) begin
            while (pending_meas.size() >= 8) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 15) begin
                m.a_first  = 8'($urandom);
                m.a_second = 8'($urandom);
                m.diff     = $urandom;
                m.err      = $urandom;
                m.age      = 16'($urandom);
                m.now      = $urandom;
            end else begin
                if (n_pairs > 0 && $urandom_range(0, 9) < 7) begin
                    k = int'($urandom_range(0, n_pairs - 1));
                    m.a_first  = tbl_lo[k];
                    m.a_second = tbl_hi[k];
                end else begin
                    m.a_first  = 8'($urandom_range(0, ANCHOR_LIMIT - 1));
                    m.a_second = 8'((int'(m.a_first) + int'($urandom_range(1, ANCHOR_LIMIT - 1)))
                                    % ANCHOR_LIMIT);
                end
                if ($urandom_range(0, 1) == 1) begin
                    {m.a_first, m.a_second} = {m.a_second, m.a_first};
                end
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    clock_ms = clock_ms - $urandom_range(0, 2 * int'(back_tol) + 10);
                end else if (r < 10) begin
                    clock_ms = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, 40);
                end
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    m.age = age_limit;
                end else if (r == 1) begin
                    m.age = age_limit + 16'd1;
                end else begin
                    m.age = 16'($urandom_range(0, (age_limit < 150) ? int'(age_limit) : 150));
                end
                m.now  = clock_ms;
                m.diff = $urandom;
                m.err  = $urandom;
                r = $urandom_range(0, 49);
                if (r == 0) begin
                    m.diff[30:23] = FP_EXP_ONES;
                end else if (r == 1) begin
                    m.err[30:23] = FP_EXP_ONES;
                end
            end
            pending_meas.push_back(m);
        end
    endtask

    initial begin : stimulus
        i_rst_n                 = 1'b0;
        meas_if.valid           = 1'b0;
        meas_if.anchor_first    = '0;
        meas_if.anchor_second   = '0;
        meas_if.diff_bits       = '0;
        meas_if.diff_error_bits = '0;
        meas_if.sample_age      = '0;
        meas_if.now_time        = '0;
        res_if.ready            = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.reg_index        = '0;
        cfg_if.wr_data          = '0;
        mismatches   = 0;
        stall_cycles = 0;
        meas_busy    = 1'b0;
        quiet        = 1'b0;
        park_req     = 1'b0;
        src_gap      = 0;
        sink_gap     = 0;
        park_left    = 0;
        clock_ms     = 32'd20000;
        age_limit    = MAX_AGE_RST;
        back_tol     = BACK_TOL_RST;
        n_pairs      = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_lo[i]    = '0;
            tbl_hi[i]    = '0;
            tbl_diff[i]  = '0;
            tbl_err[i]   = '0;
            tbl_stamp[i] = '0;
            tbl_age[i]   = '0;
            tbl_valid[i] = 1'b0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_meas(8'd3,   8'd3,   32'h3F80_0000, 32'h3E00_0000, 16'd0,    32'd100);
        add_meas(8'd16,  8'd2,   32'h3F80_0000, 32'h3E00_0000, 16'd0,    32'd100);
        add_meas(8'd2,   8'd255, 32'h3F80_0000, 32'h3E00_0000, 16'd0,    32'd100);
        add_meas(8'd255, 8'd0,   32'h3F80_0000, 32'h3E00_0000, 16'd0,    32'd100);
        add_meas(8'd1,   8'd2,   32'h7F80_0000, 32'h3E00_0000, 16'd0,    32'd100);
        add_meas(8'd1,   8'd2,   32'h3F80_0000, 32'hFFC0_0000, 16'd0,    32'd100);
        add_meas(8'd1,   8'd2,   32'h3F80_0000, 32'h3E00_0000, 16'd1001, 32'd5000);
        add_meas(8'd0,   8'd1,   32'h3F80_0000, 32'h3E00_0000, 16'hFFFF, 32'd100);
        add_meas(8'd1,   8'd2,   32'h3F80_0000, 32'h3E00_0000, 16'd1000, 32'd5000);
        add_meas(8'd2,   8'd1,   32'hBF00_0000, 32'h8000_0000, 16'd0,    32'd3900);
        add_meas(8'd1,   8'd2,   32'h0000_0000, 32'h0000_0001, 16'd0,    32'd3799);
        add_meas(8'd5,   8'd4,   32'h8000_0000, 32'hBF80_0000, 16'd10,   32'd5);
        add_meas(8'd4,   8'd5,   32'h7F7F_FFFF, 32'hFF7F_FFFF, 16'd0,    32'hFFFF_FFFF);
        add_meas(8'd4,   8'd5,   32'h0000_0001, 32'h7F7F_FFFF, 16'd0,    32'h8000_0000);
        add_meas(8'd15,  8'd14,  32'hFF7F_FFFF, 32'h0080_0000, 16'd500,  32'd600);
        add_meas(8'd0,   8'd15,  32'h807F_FFFF, 32'h3F80_0000, 16'd7,    32'd7);
        add_meas(8'd15,  8'd0,   32'h4120_0000, 32'h3F00_0000, 16'd0,    32'd200);
        add_meas(8'd14,  8'd15,  32'hFF80_0000, 32'h3F00_0000, 16'd0,    32'd700);
        drain();

        add_random(200);
        park_req = 1'b1;
        add_random(200);
        drain();

        write_reg(REG_MAX_AGE,  16'hFFFF);
        write_reg(REG_BACK_TOL, 16'h0000);
        add_random(300);
        drain();

        write_reg(REG_MAX_AGE,  16'h0000);
        write_reg(REG_BACK_TOL, 16'hFFFF);
        add_random(200);
        drain();

        write_reg(REG_UNUSED,   16'h5A5A);
        write_reg(REG_MAX_AGE,  16'($urandom));
        write_reg(REG_BACK_TOL, 16'($urandom_range(0, 400)));
        add_random(300);
        drain();

        write_reg(REG_MAX_AGE,  16'd500);
        write_reg(REG_BACK_TOL, 16'd50);
        quiet = 1'b1;
        add_random(200);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
